[design/conv5x5_zero_pad_rgb_defines.svh]
// ----------------------------------------------------------------------------
// conv5x5_zero_pad_rgb assertion macros
// Short forms for the concurrent checks of the filter top level.
// ----------------------------------------------------------------------------
`ifndef CONV5X5_ZERO_PAD_RGB_DEFINES_SVH
`define CONV5X5_ZERO_PAD_RGB_DEFINES_SVH

// Condition must hold at every edge outside reset.
`define C5ZP_ASSERT_NOW(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define C5ZP_ASSERT_THEN(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/c5zp_pkg.sv]
// ----------------------------------------------------------------------------
// c5zp_pkg
// Shared constants, types and helpers of the 5x5 zero-padded RGB filter.
// ----------------------------------------------------------------------------
package c5zp_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int KERNEL_SIZE = 5;
  localparam int CHANNELS    = 3;
  localparam int RAD         = KERNEL_SIZE / 2;
  localparam int LINES       = KERNEL_SIZE - 1;
  localparam int NCOEF       = (RAD + 1) * (RAD + 2) / 2;
  localparam int PAIRS       = NCOEF / 2;

  localparam int PIX_W      = 8;
  localparam int COEF_W     = 16;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int ROW_W      = HEIGHT_W + 1;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int LAG_W      = WIDTH_W + 1;
  localparam int GSUM_W     = PIX_W + 3;
  localparam int PROD_W     = GSUM_W + COEF_W;
  localparam int ACC_W      = PIX_W + COEF_W + $clog2(KERNEL_SIZE * KERNEL_SIZE);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_COEF_CENTER,
    REG_COEF_NEAR_AXIS,
    REG_COEF_FAR_AXIS,
    REG_COEF_NEAR_DIAG,
    REG_COEF_MIXED,
    REG_COEF_FAR_DIAG
  } reg_idx_t;

  typedef logic [CHANNELS-1:0][PIX_W-1:0] pix_t;
  typedef logic [KERNEL_SIZE-1:0][CHANNELS-1:0][PIX_W-1:0] slice_t;
  typedef logic [NCOEF-1:0][COEF_W-1:0] coef_arr_t;

  localparam coef_arr_t COEF_RESET = {16'd2417, 16'd2567, 16'd2725,
                                      16'd2619, 16'd2780, 16'd2837};
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic                   emit;
    logic                   last;
    logic [KERNEL_SIZE-1:0] col_ok;
    logic [KERNEL_SIZE-1:0] row_ok;
  } tap_ctrl_t;

  typedef struct packed {
    pix_t pix;
    logic last;
  } out_word_t;

  // Coefficient slot of window tap (row k, column j); symmetric kernel.
  function automatic int tap_slot(int k, int j);
    int ady;
    int adx;
    int lo;
    int hi;
    ady = (k > RAD) ? k - RAD : RAD - k;
    adx = (j > RAD) ? j - RAD : RAD - j;
    lo  = (ady < adx) ? ady : adx;
    hi  = (ady < adx) ? adx : ady;
    return lo * (RAD + 1) - lo * (lo - 1) / 2 + (hi - lo);
  endfunction

endpackage

[design/c5zp_in_if.sv]
// ----------------------------------------------------------------------------
// c5zp_in_if
// Input pixel channel: valid/ready handshake with one raster pixel per word.
// ----------------------------------------------------------------------------
interface c5zp_in_if;
  logic                       valid;
  logic                       ready;
  logic [c5zp_pkg::PIX_W-1:0] in_red;
  logic [c5zp_pkg::PIX_W-1:0] in_green;
  logic [c5zp_pkg::PIX_W-1:0] in_blue;
  logic                       flush;

  modport source (output valid, in_red, in_green, in_blue, flush, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, flush, output ready);
endinterface

[design/c5zp_out_if.sv]
// ----------------------------------------------------------------------------
// c5zp_out_if
// Output pixel channel: valid/ready handshake with one filtered pixel per word.
// ----------------------------------------------------------------------------
interface c5zp_out_if;
  logic                       valid;
  logic                       ready;
  logic [c5zp_pkg::PIX_W-1:0] out_red;
  logic [c5zp_pkg::PIX_W-1:0] out_green;
  logic [c5zp_pkg::PIX_W-1:0] out_blue;
  logic                       frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

[design/conv5x5_zero_pad_rgb.sv]
// ----------------------------------------------------------------------------
// conv5x5_zero_pad_rgb
// 5x5 symmetric-kernel filter of an RGB raster stream, zero padded at edges.
// ----------------------------------------------------------------------------
// Throughput: one word per clock in and out while credits remain and the sink
//   is ready; the four row cells and the multiply pipeline then take a new pixel every cycle.
// Pipeline: once input word k+2*width+2 is taken, the result for pixel k passes
//   through window load, pre-add, multiply, pair sum and output queue.
// Reset: position counters, credits and output queue clear; width, height and
//   weights return to defaults; row memories keep stale data, masked by taps.
module conv5x5_zero_pad_rgb (
  input  logic                                clk,
  input  logic                                rst,
  c5zp_in_if.sink                             pix_in,
  c5zp_out_if.source                          pix_out,
  input  logic                                cfg_wen,
  input  logic [c5zp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [c5zp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int K  = c5zp_pkg::KERNEL_SIZE;
  localparam int R  = c5zp_pkg::RAD;
  localparam int WW = c5zp_pkg::WIDTH_W;
  localparam int HW = c5zp_pkg::HEIGHT_W;
  localparam int CW = c5zp_pkg::COL_W;
  localparam int RW = c5zp_pkg::ROW_W;
  localparam int LW = c5zp_pkg::LAG_W;
  localparam int FA = c5zp_pkg::FIFO_AW;
  localparam int FD = c5zp_pkg::FIFO_DEPTH;

  function automatic logic [WW-1:0] clamp_width(logic [WW-1:0] v);
    if (v == '0) return WW'(1);
    if (int'(v) > c5zp_pkg::MAX_WIDTH) return WW'(c5zp_pkg::MAX_WIDTH);
    return v;
  endfunction

  function automatic logic [HW-1:0] clamp_height(logic [HW-1:0] v);
    if (v == '0) return HW'(1);
    if (int'(v) > c5zp_pkg::MAX_HEIGHT) return HW'(c5zp_pkg::MAX_HEIGHT);
    return v;
  endfunction

  function automatic c5zp_pkg::pix_t make_pix(logic [c5zp_pkg::PIX_W-1:0] r,
                                             logic [c5zp_pkg::PIX_W-1:0] g,
                                             logic [c5zp_pkg::PIX_W-1:0] b);
    c5zp_pkg::pix_t p;
    for (int i = 0; i < c5zp_pkg::CHANNELS; i++) begin
      case (i)
        0:       p[i] = r;
        1:       p[i] = g;
        2:       p[i] = b;
        default: p[i] = '0;
      endcase
    end
    return p;
  endfunction

  function automatic logic [c5zp_pkg::PIX_W-1:0] get_chan(c5zp_pkg::pix_t p, int k);
    logic [c5zp_pkg::PIX_W-1:0] c;
    c = '0;
    for (int i = 0; i < c5zp_pkg::CHANNELS; i++) begin
      if (i == k) c = p[i];
    end
    return c;
  endfunction

  function automatic logic [c5zp_pkg::CFG_IDX_W-1:0] CFG_IDX_W_SUB(
      logic [c5zp_pkg::CFG_IDX_W-1:0] idx);
    return idx - c5zp_pkg::CFG_IDX_W'(c5zp_pkg::REG_COEF_CENTER);
  endfunction

  // configuration and position state
  logic [WW-1:0]        w_eff;
  logic [HW-1:0]        h_eff;
  c5zp_pkg::coef_arr_t  coef;
  logic [CW-1:0]        in_col;
  logic [RW-1:0]        in_row;
  logic [LW-1:0]        lag_cnt;
  logic [CW-1:0]        ox;
  logic [HW-1:0]        oy;
  logic [FA:0]          outstanding;

  logic                 received, accept, go, emit, last, pop, col_wrap;
  logic [LW-1:0]        lag;
  c5zp_pkg::tap_ctrl_t  ctrl0;

  // first stage
  logic                 v1;
  c5zp_pkg::pix_t       pix1;
  logic [CW-1:0]        col1;
  c5zp_pkg::tap_ctrl_t  ctrl1;

  c5zp_pkg::pix_t       cell_q  [c5zp_pkg::LINES];
  c5zp_pkg::pix_t       cell_in [c5zp_pkg::LINES];
  c5zp_pkg::slice_t     slice;

  logic                 res_valid;
  c5zp_pkg::out_word_t  res;

  c5zp_pkg::out_word_t  fifo_mem [FD];
  logic [FA-1:0]        wr_ptr, rd_ptr;
  logic [FA:0]          fifo_cnt;
  c5zp_pkg::out_word_t  head;

  assign lag      = LW'({w_eff, 1'b0}) + LW'(2);
  assign received = in_row >= RW'(h_eff);
  assign pix_in.ready = outstanding < (FA + 1)'(FD);
  assign accept   = pix_in.valid && pix_in.ready;
  // drop a flush word while pixels are still expected
  assign go       = accept && !(pix_in.flush && !received);
  assign emit     = lag_cnt == lag;
  assign last     = (WW'(ox) == w_eff - WW'(1)) && (oy == h_eff - HW'(1));
  assign col_wrap = WW'(in_col) + WW'(1) >= w_eff;
  assign pop      = pix_out.valid && pix_out.ready;

  always_comb begin
    ctrl0.emit = emit;
    ctrl0.last = last;
    for (int j = 0; j < K; j++) begin
      ctrl0.col_ok[j] = (int'(ox) + j - R >= 0) && (int'(ox) + j - R < int'(w_eff));
    end
    for (int k = 0; k < K; k++) begin
      ctrl0.row_ok[k] = (int'(oy) + R - k >= 0) && (int'(oy) + R - k < int'(h_eff));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff       <= c5zp_pkg::WIDTH_RESET;
      h_eff       <= c5zp_pkg::HEIGHT_RESET;
      coef        <= c5zp_pkg::COEF_RESET;
      in_col      <= '0;
      in_row      <= '0;
      lag_cnt     <= '0;
      ox          <= '0;
      oy          <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        c5zp_pkg::REG_FRAME_WIDTH: begin
          w_eff   <= clamp_width(cfg_data[WW-1:0]);
          in_col  <= '0;
          in_row  <= '0;
          lag_cnt <= '0;
          ox      <= '0;
          oy      <= '0;
        end
        c5zp_pkg::REG_FRAME_HEIGHT: begin
          h_eff   <= clamp_height(cfg_data[HW-1:0]);
          in_col  <= '0;
          in_row  <= '0;
          lag_cnt <= '0;
          ox      <= '0;
          oy      <= '0;
        end
        default: begin
          coef[CFG_IDX_W_SUB(cfg_index)] <= cfg_data[c5zp_pkg::COEF_W-1:0];
        end
      endcase
    end else if (go) begin
      if (emit && last) begin
        // frame done: restart positions
        in_col  <= '0;
        in_row  <= '0;
        lag_cnt <= '0;
        ox      <= '0;
        oy      <= '0;
      end else begin
        if (col_wrap) begin
          in_col <= '0;
          in_row <= in_row + RW'(1);
        end else begin
          in_col <= in_col + CW'(1);
        end
        if (!emit) begin
          lag_cnt <= lag_cnt + LW'(1);
        end else if (WW'(ox) + WW'(1) >= w_eff) begin
          ox <= '0;
          oy <= oy + HW'(1);
        end else begin
          ox <= ox + CW'(1);
        end
      end
    end
  end

  // credits: results promised but not yet taken
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + (FA + 1)'(go && emit) - (FA + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= go;
    end
    pix1  <= make_pix(pix_in.in_red, pix_in.in_green, pix_in.in_blue);
    col1  <= in_col;
    ctrl1 <= ctrl0;
  end

  // row cells: cell i holds the row i+1 above the incoming one
  always_comb begin
    slice[0] = pix1;
    for (int i = 0; i < c5zp_pkg::LINES; i++) begin
      cell_in[i]   = (i == 0) ? pix1 : cell_q[(i == 0) ? 0 : i - 1];
      slice[i + 1] = cell_q[i];
    end
  end

  for (genvar gi = 0; gi < c5zp_pkg::LINES; gi++) begin : g_cell
    c5zp_line_cell u_cell (
      .clk     (clk),
      .rd_en   (go),
      .rd_addr (in_col),
      .wr_en   (v1),
      .wr_addr (col1),
      .wr_data (cell_in[gi]),
      .q       (cell_q[gi])
    );
  end

  c5zp_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ctrl   (ctrl1),
    .in_slice  (slice),
    .coef      (coef),
    .res_valid (res_valid),
    .res       (res)
  );

  // output queue, sized by the credit limit
  always_ff @(posedge clk) begin
    if (res_valid) begin
      fifo_mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      if (res_valid) wr_ptr <= wr_ptr + FA'(1);
      if (pop)       rd_ptr <= rd_ptr + FA'(1);
      fifo_cnt <= fifo_cnt + (FA + 1)'(res_valid) - (FA + 1)'(pop);
    end
  end

  assign head              = fifo_mem[rd_ptr];
  assign pix_out.valid     = fifo_cnt != '0;
  assign pix_out.out_red   = get_chan(head.pix, 0);
  assign pix_out.out_green = get_chan(head.pix, 1);
  assign pix_out.out_blue  = get_chan(head.pix, 2);
  assign pix_out.frame_end = head.last;

`include "conv5x5_zero_pad_rgb_defines.svh"

  `C5ZP_ASSERT_NOW(a_credit_covers_queue, fifo_cnt <= outstanding, "queue holds more than credited")
  `C5ZP_ASSERT_NOW(a_queue_no_overflow, !(res_valid && !pop && fifo_cnt == (FA + 1)'(FD)), "output queue overflow")
  `C5ZP_ASSERT_THEN(a_frame_restart, go && emit && last && !cfg_wen, ox == '0 && oy == '0 && in_col == '0 && lag_cnt == '0, "positions not cleared after frame end")

endmodule

[design/c5zp_line_cell.sv]
// ----------------------------------------------------------------------------
// c5zp_line_cell
// One row delay of the line buffer chain: a row memory that hands the pixel
// of the row above to the next cell.
// ----------------------------------------------------------------------------
module c5zp_line_cell (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [c5zp_pkg::COL_W-1:0]  rd_addr,
  input  logic                        wr_en,
  input  logic [c5zp_pkg::COL_W-1:0]  wr_addr,
  input  c5zp_pkg::pix_t              wr_data,
  output c5zp_pkg::pix_t              q
);

  c5zp_pkg::pix_t mem [c5zp_pkg::MAX_WIDTH];
  c5zp_pkg::pix_t ram_q;
  c5zp_pkg::pix_t fwd_data;
  logic           fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      ram_q    <= mem[rd_addr];
      // bypass a write to the same column in the same cycle
      fwd      <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  assign q = fwd ? fwd_data : ram_q;

endmodule

[design/c5zp_filter.sv]
// ----------------------------------------------------------------------------
// c5zp_filter
// 5x5 window shift register, symmetric pre-add, coefficient multiply and
// summation pipeline with truncation and saturation.
// ----------------------------------------------------------------------------
module c5zp_filter (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  c5zp_pkg::tap_ctrl_t  in_ctrl,
  input  c5zp_pkg::slice_t     in_slice,
  input  c5zp_pkg::coef_arr_t  coef,
  output logic                 res_valid,
  output c5zp_pkg::out_word_t  res
);

  localparam int K  = c5zp_pkg::KERNEL_SIZE;
  localparam int CH = c5zp_pkg::CHANNELS;
  localparam int NC = c5zp_pkg::NCOEF;
  localparam int NP = c5zp_pkg::PAIRS;
  localparam int GW = c5zp_pkg::GSUM_W;
  localparam int PW = c5zp_pkg::PROD_W;
  localparam int AW = c5zp_pkg::ACC_W;
  localparam int SH = c5zp_pkg::COEF_W;
  localparam int XW = c5zp_pkg::PIX_W;

  c5zp_pkg::slice_t    win [K];
  c5zp_pkg::tap_ctrl_t ctrl2;
  logic                v2, v3, v4, v5;
  logic                last3, last4, last5;

  logic [CH-1:0][NC-1:0][GW-1:0] gsum;
  logic [CH-1:0][NC-1:0][GW-1:0] g3;
  logic [CH-1:0][NC-1:0][PW-1:0] prod4;
  logic [CH-1:0][NP-1:0][AW-1:0] sum5;
  logic [CH-1:0][AW-1:0]         total;

  // shift one column slice in per item
  always_ff @(posedge clk) begin
    if (in_valid) begin
      for (int j = 0; j < K - 1; j++) begin
        win[j] <= win[j + 1];
      end
      win[K - 1] <= in_slice;
    end
    ctrl2 <= in_ctrl;
  end

  // pre-add taps that share a weight, out-of-frame taps dropped
  always_comb begin
    gsum = '0;
    for (int k = 0; k < K; k++) begin
      for (int j = 0; j < K; j++) begin
        if (ctrl2.row_ok[k] && ctrl2.col_ok[j]) begin
          for (int c = 0; c < CH; c++) begin
            gsum[c][c5zp_pkg::tap_slot(k, j)] = gsum[c][c5zp_pkg::tap_slot(k, j)] +
                                                GW'(win[j][k][c]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    g3    <= gsum;
    last3 <= ctrl2.last;
    for (int c = 0; c < CH; c++) begin
      for (int s = 0; s < NC; s++) begin
        prod4[c][s] <= PW'(g3[c][s] * coef[s]);
      end
    end
    last4 <= last3;
    for (int c = 0; c < CH; c++) begin
      for (int i = 0; i < NP; i++) begin
        sum5[c][i] <= AW'(prod4[c][2 * i]) + AW'(prod4[c][2 * i + 1]);
      end
    end
    last5 <= last4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v2 <= in_valid && in_ctrl.emit;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_comb begin
    total = '0;
    for (int c = 0; c < CH; c++) begin
      for (int i = 0; i < NP; i++) begin
        total[c] = total[c] + sum5[c][i];
      end
    end
    for (int c = 0; c < CH; c++) begin
      // drop the fraction, clip at full scale
      if (|total[c][AW-1:SH+XW]) begin
        res.pix[c] = '1;
      end else begin
        res.pix[c] = total[c][SH+XW-1:SH];
      end
    end
    res.last = last5;
  end

  assign res_valid = v5;

endmodule
